// ----- rtl/core/ffca_pkg.sv -----
// Shared types and constants for the first-fit coalescing allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package ffca_pkg;

  // Default sizing
  localparam int unsigned HEAP_BYTES_DEF = 65536;
  localparam int unsigned MAX_RANGES_DEF = 16;

  // Fixed field widths of the request and result
  localparam int unsigned WORDS_W = 15;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned REL_W   = 17;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned GRANT_W = 16;
  localparam int unsigned FREE_W  = 5;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE      = 5'd0,
    OP_LOAD      = 5'd1,
    OP_RD        = 5'd2,
    OP_RD_NEXT   = 5'd3,
    OP_RD_PREV   = 5'd4,
    OP_RD_POSM1  = 5'd5,
    OP_INC       = 5'd6,
    OP_SET_POS   = 5'd7,
    OP_TRIM      = 5'd8,
    OP_GRANT     = 5'd9,
    OP_WR_DOWN   = 5'd10,
    OP_WR_UP     = 5'd11,
    OP_INSERT    = 5'd12,
    OP_MERGE_R   = 5'd13,
    OP_MERGE_L   = 5'd14,
    OP_DEC_COUNT = 5'd15,
    OP_FAIL      = 5'd16,
    OP_FULL      = 5'd17
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  // Datapath flags seen by the controller
  typedef struct packed {
    logic is_free;   // latched request is a free
    logic len_zero;  // free of zero length
    logic full;      // table holds the maximum number of ranges
    logic too_big;   // allocate larger than the heap
    logic cnt_zero;  // table is empty
    logic at_end;    // idx == count
    logic next_end;  // idx + 1 >= count
    logic fits;      // read range length >= requested bytes
    logic exact;     // read range length == requested bytes
    logic below;     // freed end lies beyond read range start
    logic at_pos;    // idx == insert position
    logic touch_r;   // current range ends where read range starts
    logic touch_l;   // read range ends where current range starts
    logic pos_zero;  // insert position is the first entry
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ffca_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module ffca_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

// ----- rtl/core/ffca_dp.sv -----
// Datapath of the allocator: free-range table in RAM, scan index, count and result.
// Depends on ffca_pkg and ffca_ram.
`default_nettype none

module ffca_dp #(
  parameter int unsigned HEAP_BYTES      = ffca_pkg::HEAP_BYTES_DEF,
  parameter int unsigned MAX_FREE_RANGES = ffca_pkg::MAX_RANGES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ffca_pkg::dp_cmd_t            cmd,
  output ffca_pkg::dp_stat_t                stat,
  input  wire logic                         in_action,
  input  wire logic [ffca_pkg::WORDS_W-1:0] in_words,
  input  wire logic [ffca_pkg::OFF_W-1:0]   in_offset,
  input  wire logic [ffca_pkg::REL_W-1:0]   in_bytes,
  output ffca_pkg::status_t                 res_status,
  output logic      [ffca_pkg::GRANT_W-1:0] res_grant,
  output logic      [ffca_pkg::FREE_W-1:0]  res_free
);

  import ffca_pkg::*;

  // Range values must hold any start or length: freed lengths reach 2^17-1
  localparam int unsigned HEAP_W = $clog2(HEAP_BYTES + 1);
  localparam int unsigned VAL_W  = (HEAP_W > REL_W) ? HEAP_W : REL_W;
  localparam int unsigned CNT_W  = $clog2(MAX_FREE_RANGES + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_FREE_RANGES);
  localparam int unsigned WORD_W = 2 * VAL_W;

  logic               is_free;
  logic [VAL_W-1:0]   bytes;
  logic [VAL_W-1:0]   cur_start;
  logic [VAL_W-1:0]   cur_len;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   pos;
  logic [VAL_W-1:0]   grant;
  status_t            status;
  logic               written0;
  logic               rd_init;

  logic               we;
  logic [IDX_W-1:0]   wa;
  logic [WORD_W-1:0]  wd;
  logic [IDX_W-1:0]   ra;
  logic [WORD_W-1:0]  q;

  logic [VAL_W-1:0]   rd_start;
  logic [VAL_W-1:0]   rd_len;
  logic [CNT_W:0]     idx_p1;
  logic [CNT_W-1:0]   idx_m1;
  logic [CNT_W-1:0]   pos_m1;
  logic [VAL_W:0]     cur_end;
  logic [VAL_W:0]     rd_end;
  logic [CNT_W+FREE_W-1:0] cnt_ext;

  // Table storage, word = {length, start}
  ffca_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_FREE_RANGES)
  ) u_ram (
    .clk(clk),
    .we (we),
    .wa (wa),
    .wd (wd),
    .ra (ra),
    .rd (q)
  );

  // Entry 0 reads as the whole heap until it is first written
  assign rd_start = rd_init ? '0 : q[VAL_W-1:0];
  assign rd_len   = rd_init ? VAL_W'(HEAP_BYTES) : q[WORD_W-1:VAL_W];

  assign idx_p1  = {1'b0, idx} + 1'b1;
  assign idx_m1  = idx - 1'b1;
  assign pos_m1  = pos - 1'b1;
  assign cur_end = {1'b0, cur_start} + {1'b0, cur_len};
  assign rd_end  = {1'b0, rd_start} + {1'b0, rd_len};

  // Status flags
  always_comb begin
    stat.is_free  = is_free;
    stat.len_zero = (cur_len == '0);
    stat.full     = ({1'b0, count} >= (CNT_W+1)'(MAX_FREE_RANGES));
    stat.too_big  = ({1'b0, bytes} > (VAL_W+1)'(HEAP_BYTES));
    stat.cnt_zero = (count == '0);
    stat.at_end   = (idx == count);
    stat.next_end = (idx_p1 >= {1'b0, count});
    stat.fits     = (bytes <= rd_len);
    stat.exact    = (bytes == rd_len);
    stat.below    = (cur_end > {1'b0, rd_start});
    stat.at_pos   = (idx == pos);
    stat.touch_r  = (cur_end == {1'b0, rd_start});
    stat.touch_l  = (rd_end == {1'b0, cur_start});
    stat.pos_zero = (pos == '0);
  end

  // RAM port selection per micro-operation
  always_comb begin
    we = 1'b0;
    wa = idx[IDX_W-1:0];
    wd = q;
    ra = idx[IDX_W-1:0];
    case (cmd.op)
      OP_RD_NEXT:  ra = idx_p1[IDX_W-1:0];
      OP_RD_PREV:  ra = idx_m1[IDX_W-1:0];
      OP_RD_POSM1: ra = pos_m1[IDX_W-1:0];
      OP_TRIM: begin
        we = 1'b1;
        wd = {rd_len - bytes, rd_start + bytes};
      end
      OP_WR_DOWN,
      OP_WR_UP: begin
        we = 1'b1;
        wd = {rd_len, rd_start};
      end
      OP_INSERT: begin
        we = 1'b1;
        wd = {cur_len, cur_start};
      end
      OP_MERGE_R: begin
        we = 1'b1;
        wd = {cur_len + rd_len, cur_start};
      end
      OP_MERGE_L: begin
        we = 1'b1;
        wd = {rd_len + cur_len, rd_start};
      end
      default: ;
    endcase
  end

  // Reset marker for entry 0, sampled alongside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      written0 <= 1'b0;
      rd_init  <= 1'b0;
    end else begin
      rd_init <= (ra == '0) && !written0;
      if (we && (wa == '0)) begin
        written0 <= 1'b1;
      end
    end
  end

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(1);
    end else begin
      case (cmd.op)
        OP_INSERT:    count <= count + 1'b1;
        OP_DEC_COUNT: count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  // Index, position, request and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        is_free   <= in_action;
        bytes     <= VAL_W'({in_words, 2'b00});
        cur_start <= VAL_W'(in_offset);
        cur_len   <= VAL_W'(in_bytes);
        idx       <= '0;
        status    <= ST_DONE;
        grant     <= '0;
      end
      OP_INC:     idx <= idx_p1[CNT_W-1:0];
      OP_SET_POS: begin
        pos <= idx;
        idx <= count;
      end
      OP_TRIM,
      OP_GRANT:   grant <= rd_start;
      OP_WR_DOWN: idx <= idx_p1[CNT_W-1:0];
      OP_WR_UP:   idx <= idx_m1;
      OP_MERGE_R: begin
        cur_len <= cur_len + rd_len;
        idx     <= idx_p1[CNT_W-1:0];
      end
      OP_MERGE_L:  idx <= idx_p1[CNT_W-1:0];
      OP_RD_POSM1: idx <= pos_m1;
      OP_FAIL:     status <= ST_NOFIT;
      OP_FULL:     status <= ST_FULL;
      default: ;
    endcase
  end

  assign cnt_ext    = (CNT_W+FREE_W)'(count);
  assign res_status = status;
  assign res_grant  = grant[GRANT_W-1:0];
  assign res_free   = cnt_ext[FREE_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/ffca_ctrl.sv -----
// Controller of the allocator: sequences table scans, shifts and merges.
// Depends on ffca_pkg; drives ffca_dp through command and status structs.
`default_nettype none

module ffca_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  input  wire ffca_pkg::dp_stat_t stat,
  output ffca_pkg::dp_cmd_t       cmd
);

  import ffca_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_DECIDE = 16'h0002,
    S_A_RD   = 16'h0004,
    S_A_CMP  = 16'h0008,
    S_F_CHK  = 16'h0010,
    S_F_CMP  = 16'h0020,
    S_UP_CHK = 16'h0040,
    S_UP_WR  = 16'h0080,
    S_MR_CHK = 16'h0100,
    S_MR_CMP = 16'h0200,
    S_ML_CHK = 16'h0400,
    S_ML_CMP = 16'h0800,
    S_DR_RD  = 16'h1000,
    S_DR_WR  = 16'h2000,
    S_OUT    = 16'h4000
  } state_t;

  state_t state;
  state_t state_next;
  logic   ret_left;       // after a drop, go on to the left merge
  logic   ret_left_next;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret_left <= 1'b0;
    end else begin
      state    <= state_next;
      ret_left <= ret_left_next;
    end
  end

  // Next state and micro-operation
  always_comb begin
    state_next    = state;
    ret_left_next = ret_left;
    cmd.op        = OP_NONE;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_free) begin
          if (stat.len_zero) begin
            state_next = S_OUT;
          end else if (stat.full) begin
            cmd.op     = OP_FULL;
            state_next = S_OUT;
          end else begin
            state_next = S_F_CHK;
          end
        end else if (stat.too_big || stat.cnt_zero) begin
          cmd.op     = OP_FAIL;
          state_next = S_OUT;
        end else begin
          state_next = S_A_RD;
        end
      end
      // first-fit scan
      S_A_RD: begin
        cmd.op     = OP_RD;
        state_next = S_A_CMP;
      end
      S_A_CMP: begin
        if (stat.fits) begin
          if (stat.exact) begin
            cmd.op        = OP_GRANT;
            ret_left_next = 1'b0;
            state_next    = S_DR_RD;
          end else begin
            cmd.op     = OP_TRIM;
            state_next = S_OUT;
          end
        end else if (stat.next_end) begin
          cmd.op     = OP_FAIL;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_INC;
          state_next = S_A_RD;
        end
      end
      // search for the insert position
      S_F_CHK: begin
        if (stat.at_end) begin
          cmd.op     = OP_SET_POS;
          state_next = S_UP_CHK;
        end else begin
          cmd.op     = OP_RD;
          state_next = S_F_CMP;
        end
      end
      S_F_CMP: begin
        if (stat.below) begin
          cmd.op     = OP_INC;
          state_next = S_F_CHK;
        end else begin
          cmd.op     = OP_SET_POS;
          state_next = S_UP_CHK;
        end
      end
      // open a slot by shifting the tail up
      S_UP_CHK: begin
        if (stat.at_pos) begin
          cmd.op     = OP_INSERT;
          state_next = S_MR_CHK;
        end else begin
          cmd.op     = OP_RD_PREV;
          state_next = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.op     = OP_WR_UP;
        state_next = S_UP_CHK;
      end
      // merge with the successor
      S_MR_CHK: begin
        if (stat.next_end) begin
          state_next = S_ML_CHK;
        end else begin
          cmd.op     = OP_RD_NEXT;
          state_next = S_MR_CMP;
        end
      end
      S_MR_CMP: begin
        if (stat.touch_r) begin
          cmd.op        = OP_MERGE_R;
          ret_left_next = 1'b1;
          state_next    = S_DR_RD;
        end else begin
          state_next = S_ML_CHK;
        end
      end
      // merge the predecessor with it
      S_ML_CHK: begin
        if (stat.pos_zero) begin
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_RD_POSM1;
          state_next = S_ML_CMP;
        end
      end
      S_ML_CMP: begin
        if (stat.touch_l) begin
          cmd.op        = OP_MERGE_L;
          ret_left_next = 1'b0;
          state_next    = S_DR_RD;
        end else begin
          state_next = S_OUT;
        end
      end
      // drop the entry at idx by shifting the tail down
      S_DR_RD: begin
        if (stat.next_end) begin
          cmd.op     = OP_DEC_COUNT;
          state_next = ret_left ? S_ML_CHK : S_OUT;
        end else begin
          cmd.op     = OP_RD_NEXT;
          state_next = S_DR_WR;
        end
      end
      S_DR_WR: begin
        cmd.op     = OP_WR_DOWN;
        state_next = S_DR_RD;
      end
      S_OUT: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/first_fit_coalescing_allocator.sv -----
// Top level of the first-fit coalescing allocator: stream ports, controller and datapath.
// Depends on ffca_pkg, ffca_ctrl, ffca_dp and ffca_ram.
`default_nettype none

// First-fit allocator over a sorted table of free byte ranges, one range
// covering the whole heap after reset. An allocate request takes its size
// from the first range large enough; a free request is inserted in offset
// order and merged with touching neighbors. Each request gives exactly one
// result. The block handles one request at a time: s_tready is high only
// while idle and drops until the result has been taken. The table lives in a
// single-write, single-read RAM, so each visited entry is read in one state
// and used in the next. An allocate that fits exactly drops that entry by
// shifting the tail down; one that finds no fit reports NOFIT. A request
// that is too large, an allocate on an empty table, a zero-length free and
// a free on a full table are answered without a scan. A free scans the
// ranges below its place, shifts the ranges above it up, and each merge
// adds a shift down. A result waits while m_tready is low.
// No clearing pass is needed after reset.
module first_fit_coalescing_allocator #(
  parameter int unsigned HEAP_BYTES      = ffca_pkg::HEAP_BYTES_DEF,
  parameter int unsigned MAX_FREE_RANGES = ffca_pkg::MAX_RANGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // request_words[14:0], release_offset[30:15],
                                     // release_bytes[47:31]
  input  wire logic        s_tuser,  // action (0 allocate, 1 free)
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,  // grant_offset[15:0], free_ranges[20:16], zero[23:21]
  output logic      [1:0]  m_tuser   // status
);

  import ffca_pkg::*;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  status_t              res_status;
  logic [GRANT_W-1:0]   res_grant;
  logic [FREE_W-1:0]    res_free;

  ffca_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  ffca_dp #(
    .HEAP_BYTES     (HEAP_BYTES),
    .MAX_FREE_RANGES(MAX_FREE_RANGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_action (s_tuser),
    .in_words  (s_tdata[14:0]),
    .in_offset (s_tdata[30:15]),
    .in_bytes  (s_tdata[47:31]),
    .res_status(res_status),
    .res_grant (res_grant),
    .res_free  (res_free)
  );

  assign m_tdata = {3'b000, res_free, res_grant};
  assign m_tuser = res_status;

  // One request in flight: never ready for a new one while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request accepted while a result is pending");

  // Only defined status codes are reported
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_DONE || m_tuser == ST_NOFIT || m_tuser == ST_FULL))
    else $error("undefined status code");

  // A failed request grants nothing
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_DONE) |-> (m_tdata[15:0] == '0))
    else $error("grant offset set on a failed request");

  // A dropped free leaves the table at its full size
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[20:16] == FREE_W'(MAX_FREE_RANGES)))
    else $error("table full reported with spare entries");

endmodule

`default_nettype wire
